// ----- hw/rtl/wrs_pkg.sv -----
// ============================================================================
// wrs_pkg
// Shared widths, constants, codes and control structs of the weighted
// reservoir sampler.
// ============================================================================
`default_nettype none

package wrs_pkg;

    localparam int WEIGHT_BITS   = 16;
    localparam int TOTAL_BITS    = 48;
    localparam int FRACTION_BITS = 32;

    // The divider works on the wider of the total and a Q1 fraction.
    localparam int DIV_BITS = (TOTAL_BITS > FRACTION_BITS) ? TOTAL_BITS : FRACTION_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(FRACTION_BITS + 1);

    localparam logic [63:0] LCG_MUL = 64'h9b60933458e17d7d;
    localparam logic [63:0] LCG_ADD = 64'hd737232eeccdf7ed;
    localparam logic [4:0]  LCG_SHIFT_BASE = 5'd29;
    localparam int          LCG_SHIFT_TOP  = 61;

    localparam logic [TOTAL_BITS-1:0]    TOTAL_MAX = {TOTAL_BITS{1'b1}};
    localparam logic [FRACTION_BITS:0]   VALUE_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    localparam int PADDR_BITS = 4;
    localparam int PDATA_BITS = 64;

    // Register index taken from paddr[3] (registers are 8 bytes apart).
    localparam logic REG_SEED_IDX = 1'b0;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_OFFER = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEN,
        ST_SUM,
        ST_DIV_VALUE,
        ST_PREP,
        ST_DIV_FRAC,
        ST_DONE
    } wrs_state_t;

    typedef struct packed {
        logic        load;
        logic [63:0] load_value;
        logic        start;
    } wrs_lcg_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] word;
    } wrs_lcg_rsp_t;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] den;
    } wrs_div_req_t;

    typedef struct packed {
        logic                     done;
        logic [FRACTION_BITS-1:0] quotient;
    } wrs_div_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wrs_item_if.sv -----
// ============================================================================
// wrs_item_if
// Input channel of the sampler: one command and weight per beat.
// ============================================================================
`default_nettype none

interface wrs_item_if;
    logic                            valid;
    logic                            ready;
    logic                            command;
    logic [wrs_pkg::WEIGHT_BITS-1:0] weight;

    modport source (output valid, output command, output weight, input ready);
    modport sink   (input valid, input command, input weight, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/wrs_result_if.sv -----
// ============================================================================
// wrs_result_if
// Result channel of the sampler: one selection flag and saturation flag per beat.
// ============================================================================
`default_nettype none

interface wrs_result_if;
    logic valid;
    logic ready;
    logic selected;
    logic total_saturated;

    modport source (output valid, output selected, output total_saturated, input ready);
    modport sink   (input valid, input selected, input total_saturated, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/wrs_lcg.sv -----
// ============================================================================
// wrs_lcg
// 64-bit linear congruential generator stepped with one shared 32x32
// multiplier, with a state-dependent output shift.
// ============================================================================
`default_nettype none

module wrs_lcg (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire wrs_pkg::wrs_lcg_req_t req,
    output wrs_pkg::wrs_lcg_rsp_t      rsp
);

    logic [63:0] gen_state_reg;
    logic        busy_reg;
    logic [1:0]  phase_reg;
    logic        done_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod_next;
    logic [4:0]  shift_amt;
    logic [63:0] shifted;

    // Only the low 64 bits of state * multiplier are kept, so the
    // high-by-high partial product is never needed.
    always_comb
    begin
        case (phase_reg)
            2'd0:
            begin
                mul_a = gen_state_reg[31:0];
                mul_b = wrs_pkg::LCG_MUL[31:0];
            end
            2'd1:
            begin
                mul_a = gen_state_reg[31:0];
                mul_b = wrs_pkg::LCG_MUL[63:32];
            end
            default:
            begin
                mul_a = gen_state_reg[63:32];
                mul_b = wrs_pkg::LCG_MUL[31:0];
            end
        endcase
    end

    assign prod_next = {32'h0, mul_a} * {32'h0, mul_b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_state_reg <= '0;
            busy_reg      <= 1'b0;
            phase_reg     <= 2'd0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.load)
            begin
                gen_state_reg <= req.load_value;
            end
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    gen_state_reg <= acc_reg + {prod_reg[31:0], 32'h0};
                    busy_reg      <= 1'b0;
                    done_reg      <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (busy_reg)
        begin
            case (phase_reg)
                2'd1:    acc_reg <= prod_reg + wrs_pkg::LCG_ADD;
                2'd2:    acc_reg <= acc_reg + {prod_reg[31:0], 32'h0};
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    assign shift_amt = wrs_pkg::LCG_SHIFT_BASE
                       - {2'b00, gen_state_reg[63:wrs_pkg::LCG_SHIFT_TOP]};
    assign shifted   = gen_state_reg >> shift_amt;

    assign rsp.done = done_reg;
    assign rsp.word = shifted[31:0];

endmodule

`default_nettype wire

// ----- hw/rtl/wrs_divider.sv -----
// ============================================================================
// wrs_divider
// Restoring fraction divider: floor(num * 2^FRACTION_BITS / den) for
// num < den, two quotient bits per cycle.
// ============================================================================
`default_nettype none

module wrs_divider (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire wrs_pkg::wrs_div_req_t req,
    output wrs_pkg::wrs_div_rsp_t      rsp
);

    localparam int DB = wrs_pkg::DIV_BITS;
    localparam int FB = wrs_pkg::FRACTION_BITS;
    localparam int CB = wrs_pkg::DIV_CNT_BITS;

    logic [CB-1:0] cnt_reg;
    logic          done_reg;
    logic [DB-1:0] rem_reg;
    logic [DB-1:0] den_reg;
    logic [FB-1:0] quo_reg;
    logic [DB:0]   r1;
    logic [DB:0]   r2;
    logic          ge1;
    logic          ge2;
    logic [DB-1:0] s1;
    logic [DB-1:0] s2;

    // The remainder stays below the divisor, so each doubled remainder
    // fits in one extra bit and each difference fits back in DB bits.
    always_comb
    begin
        r1  = {rem_reg, 1'b0};
        ge1 = r1 >= {1'b0, den_reg};
        s1  = ge1 ? DB'(r1 - {1'b0, den_reg}) : DB'(r1);
        r2  = {s1, 1'b0};
        ge2 = r2 >= {1'b0, den_reg};
        s2  = ge2 ? DB'(r2 - {1'b0, den_reg}) : DB'(r2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= CB'(FB);
            end
            else if (cnt_reg == CB'(1))
            begin
                cnt_reg  <= '0;
                done_reg <= 1'b1;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CB'(2);
                if (cnt_reg == CB'(2))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.num;
            den_reg <= req.den;
            quo_reg <= '0;
        end
        else if (cnt_reg == CB'(1))
        begin
            rem_reg <= s1;
            quo_reg <= {quo_reg[FB-2:0], ge1};
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= s2;
            quo_reg <= {quo_reg[FB-3:0], ge1, ge2};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/weighted_reservoir_sampler_core.sv -----
// ============================================================================
// weighted_reservoir_sampler_core
// Single-draw weighted reservoir sampler with an internal LCG and an
// iterative divider under a small sequencer.
// ============================================================================
// Usage: items carries one command per beat (begin or offer with a weight);
// results returns exactly one beat per item: selected and total_saturated.
// A begin steps the generator with a shared 32x32 multiplier and gives its
// result once the generator is done.
// An offer adds the weight to the running total, then runs the two-bit-per-
// cycle divider twice (value = weight / total, then the fraction rescale);
// when the total is zero or the weight covers it, the value is set directly
// and only the rescale division runs.
// Items are taken one at a time: ready is high only while the sequencer is
// idle, which it re-enters as the previous result is loaded for output.
// The result sits in an output register; a new item is accepted while it
// waits, and a later result holds in the sequencer until it is taken.
// The seed register (APB, address 0) loads the generator when written.
// Reset clears the seed, generator, weight total and fraction to zero.
// ============================================================================
`default_nettype none

module weighted_reservoir_sampler_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    wrs_item_if.sink                             items,
    wrs_result_if.source                         results,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [wrs_pkg::PADDR_BITS-1:0]  paddr,
    input  wire logic [wrs_pkg::PDATA_BITS-1:0]  pwdata,
    output logic      [wrs_pkg::PDATA_BITS-1:0]  prdata,
    output logic                                 pready
);

    localparam int TB = wrs_pkg::TOTAL_BITS;
    localparam int FB = wrs_pkg::FRACTION_BITS;
    localparam int WB = wrs_pkg::WEIGHT_BITS;
    localparam int DB = wrs_pkg::DIV_BITS;

    wrs_pkg::wrs_state_t   state_reg, state_next;
    wrs_pkg::wrs_lcg_req_t lcg_req;
    wrs_pkg::wrs_lcg_rsp_t lcg_rsp;
    wrs_pkg::wrs_div_req_t div_req;
    wrs_pkg::wrs_div_rsp_t div_rsp;

    logic [63:0]   seed_reg;
    logic [TB-1:0] total_reg, total_next;
    logic [FB-1:0] frac_reg, frac_next;
    logic [FB:0]   value_reg, value_next;
    logic [WB-1:0] weight_reg, weight_next;
    logic          sel_reg, sel_next;
    logic          res_sel_reg, res_sel_next;
    logic          res_sat_reg, res_sat_next;
    logic          out_valid_reg;
    logic          out_sel_reg;
    logic          out_sat_reg;
    logic          out_load;
    logic          item_accept;
    logic          cfg_write;
    logic [TB:0]   sum;
    logic [FB:0]   frac_diff;

    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite;
    assign prdata      = (paddr[3] == wrs_pkg::REG_SEED_IDX) ? seed_reg : '0;
    assign items.ready = (state_reg == wrs_pkg::ST_IDLE);
    assign item_accept = items.valid && items.ready;

    assign sum       = {1'b0, total_reg} + (TB + 1)'(weight_reg);
    assign frac_diff = {1'b0, frac_reg} - value_reg;

    always_comb
    begin
        state_next   = state_reg;
        total_next   = total_reg;
        frac_next    = frac_reg;
        value_next   = value_reg;
        weight_next  = weight_reg;
        sel_next     = sel_reg;
        res_sel_next = res_sel_reg;
        res_sat_next = res_sat_reg;
        out_load     = 1'b0;

        lcg_req.load       = cfg_write && (paddr[3] == wrs_pkg::REG_SEED_IDX);
        lcg_req.load_value = pwdata;
        lcg_req.start      = 1'b0;
        div_req.start      = 1'b0;
        div_req.num        = '0;
        div_req.den        = '0;

        unique case (state_reg)
            wrs_pkg::ST_IDLE:
            begin
                if (item_accept)
                begin
                    weight_next = items.weight;
                    if (items.command == wrs_pkg::CMD_BEGIN)
                    begin
                        lcg_req.start = 1'b1;
                        total_next    = '0;
                        state_next    = wrs_pkg::ST_GEN;
                    end
                    else
                    begin
                        state_next = wrs_pkg::ST_SUM;
                    end
                end
            end
            wrs_pkg::ST_GEN:
            begin
                if (lcg_rsp.done)
                begin
                    frac_next    = lcg_rsp.word[31 -: FB];
                    res_sel_next = 1'b0;
                    res_sat_next = 1'b0;
                    state_next   = wrs_pkg::ST_DONE;
                end
            end
            wrs_pkg::ST_SUM:
            begin
                // A carry out of the add means the total has saturated.
                total_next = sum[TB] ? wrs_pkg::TOTAL_MAX : sum[TB-1:0];
                if (total_next == '0)
                begin
                    value_next = '0;
                    state_next = wrs_pkg::ST_PREP;
                end
                else if (TB'(weight_reg) >= total_next)
                begin
                    value_next = wrs_pkg::VALUE_ONE;
                    state_next = wrs_pkg::ST_PREP;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = DB'(weight_reg);
                    div_req.den   = DB'(total_next);
                    state_next    = wrs_pkg::ST_DIV_VALUE;
                end
            end
            wrs_pkg::ST_DIV_VALUE:
            begin
                if (div_rsp.done)
                begin
                    value_next = {1'b0, div_rsp.quotient};
                    state_next = wrs_pkg::ST_PREP;
                end
            end
            wrs_pkg::ST_PREP:
            begin
                div_req.start = 1'b1;
                if ({1'b0, frac_reg} < value_reg)
                begin
                    sel_next    = 1'b1;
                    div_req.num = DB'(frac_reg);
                    div_req.den = DB'(value_reg);
                end
                else
                begin
                    sel_next    = 1'b0;
                    div_req.num = DB'(frac_diff);
                    div_req.den = DB'(wrs_pkg::VALUE_ONE - value_reg);
                end
                state_next = wrs_pkg::ST_DIV_FRAC;
            end
            wrs_pkg::ST_DIV_FRAC:
            begin
                if (div_rsp.done)
                begin
                    frac_next    = div_rsp.quotient;
                    res_sel_next = sel_reg;
                    res_sat_next = (total_reg == wrs_pkg::TOTAL_MAX);
                    state_next   = wrs_pkg::ST_DONE;
                end
            end
            wrs_pkg::ST_DONE:
            begin
                // Hold until the output register is free or being emptied.
                if (!out_valid_reg || results.ready)
                begin
                    out_load   = 1'b1;
                    state_next = wrs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wrs_pkg::ST_IDLE;
            seed_reg      <= '0;
            total_reg     <= '0;
            frac_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            frac_reg  <= frac_next;
            if (lcg_req.load)
            begin
                seed_reg <= pwdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        weight_reg  <= weight_next;
        sel_reg     <= sel_next;
        res_sel_reg <= res_sel_next;
        res_sat_reg <= res_sat_next;
        if (out_load)
        begin
            out_sel_reg <= res_sel_reg;
            out_sat_reg <= res_sat_reg;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.selected        = out_sel_reg;
    assign results.total_saturated = out_sat_reg;

    wrs_lcg u_lcg (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lcg_req),
        .rsp   (lcg_rsp)
    );

    wrs_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

`default_nettype wire
